/* hw/rtl/rce_pkg.sv */
// Shared types and constants for the residency counter extender.
// No dependencies; compile first.
package rce_pkg;

  localparam int DEF_COUNTERS = 4;

  localparam int IDX_W   = 2;
  localparam int RAW_W   = 40;
  localparam int NARROW_W = 32;
  localparam int TOTAL_W = 64;
  localparam int MUL_W   = 20;
  localparam int DIV_W   = 32;
  localparam int HALF_W  = TOTAL_W / 2;
  localparam int PART_W  = HALF_W + MUL_W;
  localparam int PROD_W  = TOTAL_W + MUL_W;
  localparam int NS_W    = 64;

  localparam int STEP_BITS     = 2;
  localparam int DIV_NS_STEPS  = PROD_W / STEP_BITS;
  localparam int CNT_W         = $clog2(DIV_NS_STEPS);

  // Microseconds: q = ((ns >> 3) * US_RECIP) >> 68 is exact for every 64-bit ns.
  localparam int US_ACC_W      = 2 * TOTAL_W;
  localparam int US_PRE_SHIFT  = 3;
  localparam int US_POST_SHIFT = TOTAL_W + 4;
  localparam int US_REM_W      = 10;
  localparam int US_MUL_STEPS  = 4;
  localparam logic [TOTAL_W-1:0] US_RECIP = 64'h20C4_9BA5_E353_F7CF;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [MUL_W-1:0] RESET_MUL = MUL_W'(1280);
  localparam logic [DIV_W-1:0] RESET_DIV = DIV_W'(1);
  localparam logic [DIV_W-1:0] NS_PER_US = DIV_W'(1000);

  typedef logic [IDX_W-1:0]   cnt_idx_t;
  typedef logic [RAW_W-1:0]   raw_t;
  typedef logic [TOTAL_W-1:0] total_t;
  typedef logic [NS_W-1:0]    time_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE  = 2'd0,
    CFG_WIDE    = 2'd1,
    CFG_MUL     = 2'd2,
    CFG_DIV     = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_ACCUM,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_DIV_NS,
    ST_US_LOAD,
    ST_US_MUL,
    ST_US_ROUND,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic accum;
    logic mul_lo;
    logic mul_hi;
    logic load_prod;
    logic div_step;
    logic load_us;
    logic us_mul;
    logic us_hi_a;
    logic us_hi_m;
    logic us_round;
    logic load_out;
  } rce_cmd_t;

  typedef struct packed {
    logic skip_in;
  } rce_stat_t;

endpackage

/* hw/rtl/rce_if.sv */
// Request channel interfaces: sample requests in, residency results out.
// Depends on rce_pkg.
interface rce_in_if;
  import rce_pkg::*;
  logic     valid;
  logic     ready;
  cnt_idx_t counter_index;
  raw_t     raw_count;
  modport source (output valid, output counter_index, output raw_count, input ready);
  modport sink   (input valid, input counter_index, input raw_count, output ready);
endinterface

interface rce_out_if;
  import rce_pkg::*;
  logic  valid;
  logic  ready;
  time_t residency_ns;
  time_t residency_us;
  modport source (output valid, output residency_ns, output residency_us, input ready);
  modport sink   (input valid, input residency_ns, input residency_us, output ready);
endinterface

/* hw/rtl/rce_ctrl.sv */
// Sequencing state machine for the residency counter extender.
// Depends on rce_pkg; drives commands into rce_datapath.
module rce_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  rce_pkg::rce_stat_t stat,
  output rce_pkg::rce_cmd_t  cmd
);
  import rce_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = stat.skip_in ? ST_FINISH : ST_UPDATE;
      ST_UPDATE:  state_nxt = ST_ACCUM;
      ST_ACCUM:   state_nxt = ST_MUL_LO;
      ST_MUL_LO:  state_nxt = ST_MUL_HI;
      ST_MUL_HI:  state_nxt = ST_SUM;
      ST_SUM: begin
        state_nxt = ST_DIV_NS;
        cnt_nxt   = CNT_W'(DIV_NS_STEPS - 1);
      end
      ST_DIV_NS: begin
        if (cnt_r == '0) state_nxt = ST_US_LOAD;
        else cnt_nxt = cnt_r - 1'b1;
      end
      ST_US_LOAD: begin
        state_nxt = ST_US_MUL;
        cnt_nxt   = CNT_W'(US_MUL_STEPS - 1);
      end
      ST_US_MUL: begin
        if (cnt_r == '0) state_nxt = ST_US_ROUND;
        else cnt_nxt = cnt_r - 1'b1;
      end
      ST_US_ROUND: state_nxt = ST_FINISH;
      ST_FINISH:  if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE:    cmd.capture   = in_valid;
      ST_UPDATE:  cmd.update    = 1'b1;
      ST_ACCUM:   cmd.accum     = 1'b1;
      ST_MUL_LO:  cmd.mul_lo    = 1'b1;
      ST_MUL_HI:  cmd.mul_hi    = 1'b1;
      ST_SUM:     cmd.load_prod = 1'b1;
      ST_DIV_NS:  cmd.div_step  = 1'b1;
      ST_US_LOAD: cmd.load_us   = 1'b1;
      ST_US_MUL: begin
        // Walk the four partial products, low halves first.
        cmd.us_mul  = 1'b1;
        cmd.us_hi_a = !cnt_r[1];
        cmd.us_hi_m = !cnt_r[0];
      end
      ST_US_ROUND: cmd.us_round = 1'b1;
      ST_FINISH: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

/* hw/rtl/rce_datapath.sv */
// Datapath: config registers, per-counter stores, split multiplier, radix-4 divider
// and reciprocal divide by 1000. Depends on rce_pkg; commanded by rce_ctrl.
module rce_datapath #(
  parameter int COUNTERS = rce_pkg::DEF_COUNTERS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rce_pkg::CFG_DATA_W-1:0] cfg_data,
  input  rce_pkg::cnt_idx_t             in_counter_index,
  input  rce_pkg::raw_t                 in_raw_count,
  input  rce_pkg::rce_cmd_t             cmd,
  output rce_pkg::rce_stat_t            stat,
  output rce_pkg::time_t                out_residency_ns,
  output rce_pkg::time_t                out_residency_us
);
  import rce_pkg::*;

  localparam int SEL_W = (COUNTERS > 1) ? $clog2(COUNTERS) : 1;

  logic             enable_r;
  logic             wide_r;
  logic [MUL_W-1:0] mul_r;
  logic [DIV_W-1:0] div_r;

  raw_t   last_r  [COUNTERS];
  total_t ext_r   [COUNTERS];

  logic [SEL_W-1:0]  sel_r;
  raw_t              raw_r;
  logic              skip_r;
  raw_t              delta_r;
  total_t            total_r;
  logic [PART_W-1:0] plo_r;
  logic [PART_W-1:0] phi_r;
  logic [PROD_W-1:0] dvd_r, dvd_w;
  logic [DIV_W-1:0]  dsr_r;
  logic [DIV_W-1:0]  rem_r, rem_w;
  time_t             quo_r, quo_w;
  time_t             ns_r;
  time_t             out_ns_r;
  time_t             out_us_r;

  logic [US_ACC_W-1:0] acc_r;
  time_t               rcp_x;
  logic [HALF_W-1:0]   rcp_a;
  logic [HALF_W-1:0]   rcp_m;
  logic [TOTAL_W-1:0]  rcp_pp;
  logic [US_ACC_W-1:0] rcp_term;
  logic [US_REM_W-1:0] q_lo_scaled;

  raw_t   raw_masked;
  raw_t   delta_full;
  total_t total_sum;

  assign out_residency_ns = out_ns_r;
  assign out_residency_us = out_us_r;

  assign stat.skip_in = !enable_r || (int'(in_counter_index) >= COUNTERS);

  assign raw_masked = wide_r ? in_raw_count
                             : {{(RAW_W - NARROW_W){1'b0}}, in_raw_count[NARROW_W-1:0]};
  assign delta_full = raw_r - last_r[sel_r];
  assign total_sum  = ext_r[sel_r] + {{(TOTAL_W - RAW_W){1'b0}}, delta_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      wide_r   <= 1'b0;
      mul_r    <= RESET_MUL;
      div_r    <= RESET_DIV;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ENABLE: enable_r <= cfg_data[0];
        CFG_WIDE:   wide_r   <= cfg_data[0];
        CFG_MUL:    mul_r    <= cfg_data[MUL_W-1:0];
        CFG_DIV:    div_r    <= cfg_data[DIV_W-1:0];
        default:    enable_r <= enable_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < COUNTERS; i++) begin
        last_r[i] <= '0;
        ext_r[i]  <= '0;
      end
    end else begin
      if (cmd.update) last_r[sel_r] <= raw_r;
      if (cmd.accum)  ext_r[sel_r]  <= total_sum;
    end
  end

  // Two restoring-division steps per cycle, MSB of the dividend first.
  always_comb begin
    logic [DIV_W:0] t;
    rem_w = rem_r;
    dvd_w = dvd_r;
    quo_w = quo_r;
    for (int b = 0; b < STEP_BITS; b++) begin
      t     = {rem_w, dvd_w[PROD_W-1]};
      dvd_w = {dvd_w[PROD_W-2:0], 1'b0};
      if (t >= {1'b0, dsr_r}) begin
        rem_w = DIV_W'(t - {1'b0, dsr_r});
        quo_w = {quo_w[NS_W-2:0], 1'b1};
      end else begin
        rem_w = t[DIV_W-1:0];
        quo_w = {quo_w[NS_W-2:0], 1'b0};
      end
    end
  end

  // One 32x32 partial product of (ns >> 3) * US_RECIP per cycle, placed by weight.
  assign rcp_x = ns_r >> US_PRE_SHIFT;

  always_comb begin
    rcp_a  = cmd.us_hi_a ? rcp_x[TOTAL_W-1:HALF_W] : rcp_x[HALF_W-1:0];
    rcp_m  = cmd.us_hi_m ? US_RECIP[TOTAL_W-1:HALF_W] : US_RECIP[HALF_W-1:0];
    rcp_pp = rcp_a * rcp_m;
    rcp_term = {{HALF_W{1'b0}}, rcp_pp, {HALF_W{1'b0}}};
    if (!cmd.us_hi_a && !cmd.us_hi_m) rcp_term = {{TOTAL_W{1'b0}}, rcp_pp};
    if (cmd.us_hi_a && cmd.us_hi_m)   rcp_term = {rcp_pp, {TOTAL_W{1'b0}}};
  end

  // The remainder is below 1000, so its low bits alone tell whether to round up.
  assign q_lo_scaled = US_REM_W'(acc_r[US_POST_SHIFT +: US_REM_W] * US_REM_W'(NS_PER_US));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sel_r  <= SEL_W'(in_counter_index);
      raw_r  <= raw_masked;
      skip_r <= stat.skip_in;
    end
    if (cmd.update) begin
      delta_r <= wide_r ? delta_full
                        : {{(RAW_W - NARROW_W){1'b0}}, delta_full[NARROW_W-1:0]};
    end
    if (cmd.accum)  total_r <= total_sum;
    if (cmd.mul_lo) plo_r <= total_r[HALF_W-1:0] * mul_r;
    if (cmd.mul_hi) phi_r <= total_r[TOTAL_W-1:HALF_W] * mul_r;
    if (cmd.load_prod) begin
      dvd_r <= {phi_r, {HALF_W{1'b0}}} + {{(PROD_W - PART_W){1'b0}}, plo_r};
      dsr_r <= div_r;
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      dvd_r <= dvd_w;
      rem_r <= rem_w;
      quo_r <= quo_w;
    end
    if (cmd.load_us) begin
      ns_r  <= quo_r;
      acc_r <= '0;
    end
    if (cmd.us_mul) acc_r <= acc_r + rcp_term;
    if (cmd.us_round) begin
      quo_r <= time_t'(acc_r[US_ACC_W-1:US_POST_SHIFT]);
      rem_r <= DIV_W'(ns_r[US_REM_W-1:0] - q_lo_scaled);
    end
    if (cmd.load_out) begin
      out_ns_r <= skip_r ? '0 : ns_r;
      out_us_r <= skip_r ? '0 : quo_r + NS_W'(rem_r != '0);
    end
  end

endmodule

/* hw/rtl/residency_counter_extender.sv */
// Top level of the residency counter extender.
// Depends on rce_pkg, rce_if, rce_ctrl and rce_datapath.
//
// Extends free-running 32- or 40-bit residency counters to 64-bit totals and
// reports each total scaled to nanoseconds (total * multiplier / divisor) and
// to microseconds rounded up. Each request on in_ch carries a counter index
// and a raw sample; exactly one result leaves on out_ch per request, in order.
// A sampled request passes, from acceptance to result, through the store
// update, the two-part 64x20 multiply, the radix-4 divider over the 84-bit
// product, a reload, the multiply-accumulate steps of the reciprocal division
// by 1000, a rounding step and the output register; the nanosecond divider
// iterations take the largest share of that time. A request that finds the
// block disabled, or an index beyond the configured counter count, skips the
// arithmetic, returns zeros through the finish state and the output register
// and leaves the per-counter state alone. A new request is taken as soon as
// the previous one has reached the output register, even while that result
// still waits on out_ch. A zero divisor gives all ones in nanoseconds. Write
// configuration through cfg_we/cfg_index/cfg_data only while no request is
// in flight. Reset clears all per-counter state at once.
module residency_counter_extender #(
  parameter int COUNTERS = rce_pkg::DEF_COUNTERS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rce_in_if.sink                         in_ch,
  rce_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [rce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rce_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rce_pkg::*;

  rce_cmd_t  cmd;
  rce_stat_t stat;

  // Sequence the request through update, multiply and both divisions.
  rce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold config, per-counter stores and the arithmetic.
  rce_datapath #(
    .COUNTERS (COUNTERS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_counter_index (in_ch.counter_index),
    .in_raw_count     (in_ch.raw_count),
    .cmd              (cmd),
    .stat             (stat),
    .out_residency_ns (out_ch.residency_ns),
    .out_residency_us (out_ch.residency_us)
  );

endmodule

/* sim/residency_counter_extender_tb.sv */
// Self-checking testbench for the residency counter extender.
// Depends on rce_pkg, rce_if and the residency_counter_extender RTL.
`timescale 1ns / 100ps

module residency_counter_extender_tb;
  import rce_pkg::*;

  localparam int NUM_COUNTERS   = DEF_COUNTERS;
  // The slowest run is about 650 requests; allow several times the cycles they need.
  localparam int CYCLE_LIMIT    = 600000;
  localparam int SETTLE_CYCLES  = 100;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_REQUESTS = 63;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    time_t ns;
    time_t us;
  } reading_t;

  // Tracks the per-counter samples and totals and queues the readings the
  // block must return, in request order.
  class residency_tracker;
    bit                enabled;
    bit                wide;
    logic [MUL_W-1:0]  mul;
    logic [DIV_W-1:0]  div;
    raw_t              last_sample [NUM_COUNTERS];
    total_t            running_total [NUM_COUNTERS];
    reading_t          expected_readings [$];
    int unsigned       failures;

    function new();
      enabled  = 1'b0;
      wide     = 1'b0;
      mul      = RESET_MUL;
      div      = RESET_DIV;
      failures = 0;
      foreach (last_sample[i]) begin
        last_sample[i]   = '0;
        running_total[i] = '0;
      end
    endfunction

    function void set_register(cfg_reg_t index, logic [CFG_DATA_W-1:0] value);
      case (index)
        CFG_ENABLE: enabled = value[0];
        CFG_WIDE:   wide    = value[0];
        CFG_MUL:    mul     = value[MUL_W-1:0];
        CFG_DIV:    div     = value[DIV_W-1:0];
        default: ;
      endcase
    endfunction

    function void log_sample(cnt_idx_t index, raw_t raw);
      raw_t         mask;
      raw_t         sample;
      raw_t         step;
      logic [127:0] product;
      reading_t     r;
      r = '0;
      if (enabled && index < NUM_COUNTERS) begin
        mask   = wide ? '1 : raw_t'({NARROW_W{1'b1}});
        sample = raw & mask;
        // The delta is taken modulo the width selected now, whatever was stored.
        step   = (sample - last_sample[index]) & mask;
        last_sample[index]   = sample;
        running_total[index] = running_total[index] + total_t'(step);
        if (div == '0) begin
          r.ns = '1;
        end else begin
          product = 128'(running_total[index]);
          product = product * 128'(mul);
          r.ns    = time_t'(product / 128'(div));
        end
        r.us = r.ns / time_t'(NS_PER_US) + time_t'((r.ns % time_t'(NS_PER_US)) != 0);
      end
      expected_readings.push_back(r);
    endfunction

    function void compare_reading(time_t ns, time_t us);
      reading_t want;
      if (expected_readings.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected reading: ns %h us %h", ns, us);
        return;
      end
      want = expected_readings.pop_front();
      if (want.ns !== ns || want.us !== us) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("reading mismatch: ns exp %h got %h, us exp %h got %h",
                   want.ns, ns, want.us, us);
      end
    endfunction

    function int unsigned pending();
      return expected_readings.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rce_in_if  in_ch ();
  rce_out_if out_ch ();

  residency_tracker tracker;
  bit               calm;                       // no idling on either side this phase
  raw_t             sent_raw [NUM_COUNTERS];    // last raw value sent per counter
  int unsigned      cycles = 0;

  residency_counter_extender uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Observe both handshakes at the edge where they complete: predict on each
  // accepted request, check each accepted reading against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        tracker.log_sample(in_ch.counter_index, in_ch.raw_count);
      if (out_ch.valid && out_ch.ready)
        tracker.compare_reading(out_ch.residency_ns, out_ch.residency_us);
    end
  end

  // Stall the result side: mostly ready, short stalls, now and then a long one.
  initial begin
    int unsigned hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else if (calm || $urandom_range(0, 99) >= 30) begin
        out_ch.ready <= 1'b1;
      end else begin
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        out_ch.ready <= 1'b0;
      end
    end
  end

  // Idle cycles before a request: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 65)
      return 0;
    if (roll < 92)
      return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // Pick the next raw value: mostly a forward step, sometimes a step back
  // (a full wrap), a value near the 32-bit wrap, or anything at all.
  function automatic raw_t next_raw(cnt_idx_t index);
    int unsigned roll;
    raw_t        wild;
    roll = $urandom_range(0, 99);
    wild = raw_t'({$urandom, $urandom});
    if (roll < 55)
      return sent_raw[index] + raw_t'($urandom_range(0, 1 << 20));
    if (roll < 70)
      return sent_raw[index] - raw_t'($urandom_range(1, 4096));
    if (roll < 80)
      return {wild[39:32], 24'hFF_FFFF, wild[7:0]};
    return wild;
  endfunction

  // Send one request; hold valid high across back-to-back requests.
  task automatic send_sample(cnt_idx_t index, raw_t raw);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.counter_index <= index;
    in_ch.raw_count     <= raw;
    sent_raw[index] = raw;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
  endtask

  // Drop valid and wait until every predicted reading has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t index, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    tracker.set_register(index, value);
    @(posedge clk);
  endtask

  // Write all four registers back to back; fill unused data bits with noise.
  task automatic write_settings(bit en, bit wide_mode, logic [MUL_W-1:0] mul,
                                logic [DIV_W-1:0] div);
    logic [CFG_DATA_W-1:0] noise;
    noise = $urandom;
    write_reg(CFG_ENABLE, {noise[CFG_DATA_W-1:1], en});
    noise = $urandom;
    write_reg(CFG_WIDE, {noise[CFG_DATA_W-1:1], wide_mode});
    noise = $urandom;
    write_reg(CFG_MUL, {noise[CFG_DATA_W-1:MUL_W], mul});
    write_reg(CFG_DIV, div);
    cfg_we <= 1'b0;
  endtask

  task automatic random_settings();
    bit               en;
    bit               wide_mode;
    logic [MUL_W-1:0] mul;
    logic [DIV_W-1:0] div;
    en        = ($urandom_range(0, 9) != 0);
    wide_mode = $urandom_range(0, 1);
    case ($urandom_range(0, 7))
      0:       mul = '0;
      1:       mul = MUL_W'(1);
      2:       mul = RESET_MUL;
      3:       mul = '1;
      default: mul = MUL_W'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       div = '0;
      1:       div = DIV_W'(1);
      2:       div = NS_PER_US;
      3:       div = '1;
      4:       div = DIV_W'($urandom_range(1, 255));
      default: div = DIV_W'($urandom);
    endcase
    calm = ($urandom_range(0, 3) == 0);
    write_settings(en, wide_mode, mul, div);
  endtask

  initial begin
    tracker = new();
    calm    = 1'b0;
    foreach (sent_raw[i])
      sent_raw[i] = '0;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_ENABLE;
    cfg_data            <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.counter_index <= '0;
    in_ch.raw_count     <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Out of reset the block is disabled: expect zeros and no state change.
    send_sample(cnt_idx_t'(0), '1);
    send_sample(cnt_idx_t'(3), '0);
    drain();

    // Enable with the reset scale in narrow mode; upper raw bits are masked,
    // a sample below the stored one wraps at 2^32.
    write_reg(CFG_ENABLE, CFG_DATA_W'(1));
    cfg_we <= 1'b0;
    send_sample(cnt_idx_t'(0), '0);
    send_sample(cnt_idx_t'(0), raw_t'(40'h00_FFFF_FFFF));
    send_sample(cnt_idx_t'(0), raw_t'(40'hFF_0000_0005));
    send_sample(cnt_idx_t'(1), raw_t'(1000));
    send_sample(cnt_idx_t'(2), '1);
    send_sample(cnt_idx_t'(3), raw_t'(1));
    drain();

    // Wide mode with the largest multiplier: products reach 60 bits.
    write_settings(1'b1, 1'b1, '1, DIV_W'(1));
    send_sample(cnt_idx_t'(2), '1);
    send_sample(cnt_idx_t'(2), '0);
    send_sample(cnt_idx_t'(0), raw_t'(40'h80_0000_0000));
    send_sample(cnt_idx_t'(1), raw_t'(40'h12_3456_789A));
    drain();

    // Back to narrow with a stored sample above 2^32; largest divisor.
    write_settings(1'b1, 1'b0, MUL_W'(1), '1);
    send_sample(cnt_idx_t'(0), raw_t'(3));
    send_sample(cnt_idx_t'(2), raw_t'(7));
    drain();

    // Zero divisor saturates the nanosecond reading.
    write_settings(1'b1, 1'b0, RESET_MUL, '0);
    send_sample(cnt_idx_t'(1), raw_t'(2000));
    send_sample(cnt_idx_t'(3), raw_t'(5));
    drain();

    // Zero multiplier.
    write_settings(1'b1, 1'b1, '0, NS_PER_US);
    send_sample(cnt_idx_t'(0), raw_t'(10));
    drain();

    // Unit scale: counter 3 reaches exactly 1000 ns, then one past it,
    // so the microsecond reading is exact once and rounded up once.
    write_settings(1'b1, 1'b0, MUL_W'(1), DIV_W'(1));
    send_sample(cnt_idx_t'(3), raw_t'(1000));
    send_sample(cnt_idx_t'(3), raw_t'(1001));
    drain();

    // Random phases, each under its own settings.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_settings();
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        cnt_idx_t index;
        index = cnt_idx_t'($urandom_range(0, NUM_COUNTERS - 1));
        send_sample(index, next_raw(index));
      end
      drain();
    end

    calm = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
